### hdl/cpp_pkg.sv
// Shared package for the controller packet parser: message kinds, the
// command record that travels from the front to the back, and the
// elaboration-time builder of the cosine and sine tables. No dependencies.
package cpp_pkg;

  localparam int TRIG_FRAC_BITS_DEF = 15;
  localparam int TRIG_ROM_SIZE      = 198;
  localparam int TRIG_HALF_ROM      = 99;
  localparam int QUEUE_DEPTH        = 4;

  // Lead and terminator bytes of the link protocol, and the zero-speed byte.
  localparam logic [7:0] LEAD_JOY    = 8'd251;
  localparam logic [7:0] LEAD_BTN    = 8'd252;
  localparam logic [7:0] LEAD_SLD    = 8'd253;
  localparam logic [7:0] LEAD_TEXT   = 8'd254;
  localparam logic [7:0] TEXT_END    = 8'd250;
  localparam logic [7:0] SPEED_ZERO  = 8'd49;

  // Message kinds as reported on the result channel.
  localparam logic [2:0] KIND_UNKNOWN  = 3'd0;
  localparam logic [2:0] KIND_JOY      = 3'd1;
  localparam logic [2:0] KIND_BTN      = 3'd2;
  localparam logic [2:0] KIND_SLD      = 3'd3;
  localparam logic [2:0] KIND_TEXT     = 3'd4;
  localparam logic [2:0] KIND_TEXT_END = 3'd5;

  // One classified message, ready for the back end.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_a;   // button id, slider id or text character
    logic [7:0] data_b;   // slider value
    logic [8:0] mag;      // joystick magnitude, zero for other kinds
    logic [7:0] angle;    // joystick angle index, 0..197
    logic       mode;     // mode bit after this message
  } cpp_cmd_t;

  // pi in Q60 and its split by 99, used to form the table angles.
  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [63:0] PI_DIV  = PI_Q60 / 99;
  localparam logic [63:0] PI_REM  = PI_Q60 % 99;
  localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;

  // Reciprocals in Q62 of the series denominators (2n-1)(2n) for cosine
  // and (2n)(2n+1) for sine, n = 1..14, element 0 first.
  localparam logic [0:13][63:0] INV_C = {
    ONE_Q62 / 64'd2,   ONE_Q62 / 64'd12,  ONE_Q62 / 64'd30,  ONE_Q62 / 64'd56,
    ONE_Q62 / 64'd90,  ONE_Q62 / 64'd132, ONE_Q62 / 64'd182, ONE_Q62 / 64'd240,
    ONE_Q62 / 64'd306, ONE_Q62 / 64'd380, ONE_Q62 / 64'd462, ONE_Q62 / 64'd552,
    ONE_Q62 / 64'd650, ONE_Q62 / 64'd756
  };
  localparam logic [0:13][63:0] INV_S = {
    ONE_Q62 / 64'd6,   ONE_Q62 / 64'd20,  ONE_Q62 / 64'd42,  ONE_Q62 / 64'd72,
    ONE_Q62 / 64'd110, ONE_Q62 / 64'd156, ONE_Q62 / 64'd210, ONE_Q62 / 64'd272,
    ONE_Q62 / 64'd342, ONE_Q62 / 64'd420, ONE_Q62 / 64'd506, ONE_Q62 / 64'd600,
    ONE_Q62 / 64'd702, ONE_Q62 / 64'd812
  };

  // (a*b) >> 62, kept to 64 bits.
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Table entry k of cosine (is_sin = 0) or sine (is_sin = 1) in Q(f),
  // rounded half away from zero and clamped to [-2^f, 2^f-1].
  function automatic logic signed [31:0] trig_entry(input int k, input bit is_sin,
                                                    input int f);
    int          j;
    int          m;
    bit          neg;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] tc;
    logic [63:0] ts;
    logic [63:0] sc;
    logic [63:0] ss;
    logic [63:0] v;
    logic [63:0] r;
    longint      e;
    longint      top;
    j = (k <= TRIG_HALF_ROM) ? k : TRIG_ROM_SIZE - k;
    m = j;
    neg = 1'b0;
    if (j > 49) begin
      m = TRIG_HALF_ROM - j;
      neg = 1'b1;
    end
    // m*PI_REM stays below 4851, where (v*662) >> 16 equals v/99 exactly.
    x  = 64'd4 * (64'(m) * PI_DIV + ((64'(m) * PI_REM * 64'd662) >> 16));
    x2 = mul_q62(x, x);
    tc = ONE_Q62;
    sc = ONE_Q62;
    ts = x;
    ss = x;
    for (int n = 1; n <= 14; n++) begin
      tc = mul_q62(mul_q62(tc, x2), INV_C[4'(n - 1)]);
      ts = mul_q62(mul_q62(ts, x2), INV_S[4'(n - 1)]);
      if (n % 2 == 1) begin
        sc = sc - tc;
        ss = ss - ts;
      end else begin
        sc = sc + tc;
        ss = ss + ts;
      end
    end
    if (is_sin) begin
      v = ss;
      neg = (k > TRIG_HALF_ROM);
    end else begin
      v = sc;
    end
    r = (v + (64'd1 << (61 - f))) >> (62 - f);
    e = neg ? -longint'(r) : longint'(r);
    top = (longint'(1) << f) - 1;
    if (e > top) begin
      e = top;
    end
    return 32'(e);
  endfunction

endpackage

### hdl/cpp_front.sv
// Front end of the controller packet parser: the byte-level message state
// machine, the mode bit and the mode_button register. Depends on cpp_pkg.
module cpp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_take,
  input  logic [7:0]        rx_byte,
  input  logic              cfg_write,
  input  logic [7:0]        cfg_data,
  output logic              push,
  output cpp_pkg::cpp_cmd_t push_cmd
);
  import cpp_pkg::*;

  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_JOY_SPEED = 4'd1;
  localparam logic [3:0] PH_JOY_DIR   = 4'd2;
  localparam logic [3:0] PH_JOY_END   = 4'd3;
  localparam logic [3:0] PH_BTN_ID    = 4'd4;
  localparam logic [3:0] PH_BTN_END   = 4'd5;
  localparam logic [3:0] PH_SLD_ID    = 4'd6;
  localparam logic [3:0] PH_SLD_VAL   = 4'd7;
  localparam logic [3:0] PH_SLD_END   = 4'd8;
  localparam logic [3:0] PH_TEXT      = 4'd9;

  logic [3:0] phase;
  logic [3:0] phase_next;
  logic [7:0] held_first;
  logic [7:0] held_first_next;
  logic [7:0] held_second;
  logic [7:0] held_second_next;
  logic       mode_flag;
  logic       mode_flag_next;
  logic [7:0] mode_button;
  logic       emit;
  cpp_cmd_t   cmd;
  logic [8:0] mag;
  logic [8:0] sum_pos;
  logic [7:0] angle;

  // Joystick magnitude and angle index from the held speed and direction.
  always_comb begin
    sum_pos = 9'(TRIG_HALF_ROM) + {1'b0, held_second};
    if (held_first >= SPEED_ZERO) begin
      mag = {held_first - SPEED_ZERO, 1'b0};
    end else begin
      mag = {SPEED_ZERO - held_first, 1'b0};
    end
    if (held_first > SPEED_ZERO) begin
      if (sum_pos >= 9'(TRIG_ROM_SIZE)) begin
        angle = 8'(sum_pos - 9'(TRIG_ROM_SIZE));
      end else begin
        angle = sum_pos[7:0];
      end
    end else if (held_first < SPEED_ZERO) begin
      if (held_second > 8'(TRIG_HALF_ROM)) begin
        angle = 8'(9'(TRIG_ROM_SIZE + TRIG_HALF_ROM) - {1'b0, held_second});
      end else begin
        angle = 8'(TRIG_HALF_ROM) - held_second;
      end
    end else begin
      angle = 8'(TRIG_HALF_ROM);
    end
  end

  always_comb begin
    phase_next       = phase;
    held_first_next  = held_first;
    held_second_next = held_second;
    mode_flag_next   = mode_flag;
    emit             = 1'b0;
    cmd              = '0;
    case (phase)
      PH_JOY_SPEED: begin
        held_first_next = rx_byte;
        phase_next      = PH_JOY_DIR;
      end
      PH_JOY_DIR: begin
        held_second_next = rx_byte;
        phase_next       = PH_JOY_END;
      end
      PH_JOY_END: begin
        emit       = 1'b1;
        cmd.kind   = KIND_JOY;
        cmd.mag    = mag;
        cmd.angle  = angle;
        phase_next = PH_IDLE;
      end
      PH_BTN_ID: begin
        held_first_next = rx_byte;
        phase_next      = PH_BTN_END;
      end
      PH_BTN_END: begin
        if (held_first == mode_button) begin
          mode_flag_next = ~mode_flag;
        end
        emit        = 1'b1;
        cmd.kind    = KIND_BTN;
        cmd.data_a  = held_first;
        phase_next  = PH_IDLE;
      end
      PH_SLD_ID: begin
        held_first_next = rx_byte;
        phase_next      = PH_SLD_VAL;
      end
      PH_SLD_VAL: begin
        held_second_next = rx_byte;
        phase_next       = PH_SLD_END;
      end
      PH_SLD_END: begin
        emit       = 1'b1;
        cmd.kind   = KIND_SLD;
        cmd.data_a = held_first;
        cmd.data_b = held_second;
        phase_next = PH_IDLE;
      end
      PH_TEXT: begin
        emit = 1'b1;
        if (rx_byte == TEXT_END) begin
          cmd.kind   = KIND_TEXT_END;
          phase_next = PH_IDLE;
        end else begin
          cmd.kind   = KIND_TEXT;
          cmd.data_a = rx_byte;
        end
      end
      default: begin
        if (rx_byte == LEAD_JOY) begin
          phase_next = PH_JOY_SPEED;
        end else if (rx_byte == LEAD_BTN) begin
          phase_next = PH_BTN_ID;
        end else if (rx_byte == LEAD_SLD) begin
          phase_next = PH_SLD_ID;
        end else if (rx_byte == LEAD_TEXT) begin
          phase_next = PH_TEXT;
        end else begin
          phase_next = PH_IDLE;
          emit       = 1'b1;
          cmd.kind   = KIND_UNKNOWN;
        end
      end
    endcase
    cmd.mode = mode_flag_next;
  end

  assign push     = byte_take && emit;
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      held_first  <= '0;
      held_second <= '0;
      mode_flag   <= 1'b0;
      mode_button <= 8'd2;
    end else begin
      if (byte_take) begin
        phase       <= phase_next;
        held_first  <= held_first_next;
        held_second <= held_second_next;
        mode_flag   <= mode_flag_next;
      end
      if (cfg_write) begin
        mode_button <= cfg_data;
      end
    end
  end

endmodule

### hdl/cpp_queue.sv
// Short command queue between the parser front end and the back end.
// Depends on cpp_pkg for the command record and the depth.
module cpp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cpp_pkg::cpp_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output cpp_pkg::cpp_cmd_t pop_cmd
);
  import cpp_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cpp_cmd_t        slots [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full      = (count == CW'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hdl/cpp_back.sv
// Back end of the controller packet parser: trig table lookup, the two
// magnitude products, truncation and the output register. Depends on cpp_pkg.
module cpp_back #(
  parameter int TRIG_FRAC_BITS = cpp_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  cpp_pkg::cpp_cmd_t cmd,
  output logic              cmd_pop,
  output logic              msg_valid,
  input  logic              msg_stall,
  output logic [2:0]        message_kind,
  output logic signed [9:0] joy_x,
  output logic signed [9:0] joy_y,
  output logic [7:0]        button_id,
  output logic [7:0]        slider_id,
  output logic [7:0]        slider_value,
  output logic [7:0]        text_char,
  output logic              mode_bit
);
  import cpp_pkg::*;

  localparam int EW = TRIG_FRAC_BITS + 2;
  localparam int PW = EW + 10;

  logic signed [EW-1:0] cos_tab [TRIG_ROM_SIZE];
  logic signed [EW-1:0] sin_tab [TRIG_ROM_SIZE];

  for (genvar k = 0; k < TRIG_ROM_SIZE; k++) begin : g_rom
    localparam logic signed [EW-1:0] COS_K = EW'(trig_entry(k, 1'b0, TRIG_FRAC_BITS));
    localparam logic signed [EW-1:0] SIN_K = EW'(trig_entry(k, 1'b1, TRIG_FRAC_BITS));
    assign cos_tab[k] = COS_K;
    assign sin_tab[k] = SIN_K;
  end

  logic                 a_valid;
  cpp_cmd_t             a_cmd;
  logic signed [PW-1:0] a_prod_x;
  logic signed [PW-1:0] a_prod_y;
  logic                 a_en;
  logic                 b_en;
  logic signed [9:0]    mag_s;
  logic signed [PW-1:0] prod_x;
  logic signed [PW-1:0] prod_y;
  logic signed [PW-1:0] bias;
  logic signed [PW-1:0] shift_x;
  logic signed [PW-1:0] shift_y;

  assign b_en    = !msg_valid || !msg_stall;
  assign a_en    = !a_valid || b_en;
  assign cmd_pop = cmd_valid && a_en;

  assign mag_s  = $signed({1'b0, cmd.mag});
  assign prod_x = mag_s * cos_tab[cmd.angle];
  assign prod_y = mag_s * sin_tab[cmd.angle];

  // Truncation toward zero: negative products get 2^F-1 added before the shift.
  assign bias    = $signed({{(PW - TRIG_FRAC_BITS){1'b0}}, {TRIG_FRAC_BITS{1'b1}}});
  assign shift_x = (a_prod_x + (a_prod_x[PW-1] ? bias : '0)) >>> TRIG_FRAC_BITS;
  assign shift_y = (a_prod_y + (a_prod_y[PW-1] ? bias : '0)) >>> TRIG_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      msg_valid <= 1'b0;
    end else begin
      if (a_en) begin
        a_valid <= cmd_valid;
      end
      if (b_en) begin
        msg_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      a_cmd    <= cmd;
      a_prod_x <= prod_x;
      a_prod_y <= prod_y;
    end
    if (b_en && a_valid) begin
      message_kind <= a_cmd.kind;
      joy_x        <= shift_x[9:0];
      joy_y        <= shift_y[9:0];
      button_id    <= (a_cmd.kind == KIND_BTN) ? a_cmd.data_a : '0;
      slider_id    <= (a_cmd.kind == KIND_SLD) ? a_cmd.data_a : '0;
      slider_value <= (a_cmd.kind == KIND_SLD) ? a_cmd.data_b : '0;
      text_char    <= (a_cmd.kind == KIND_TEXT) ? a_cmd.data_a : '0;
      mode_bit     <= a_cmd.mode;
    end
  end

endmodule

### hdl/controller_packet_parser_core.sv
// Top level of the controller packet parser: front end, command queue and
// back end. Depends on cpp_pkg, cpp_front, cpp_queue and cpp_back.
//
// Usage. Bytes of the controller link enter on rx_byte with rx_valid; a
// byte transaction completes at a rising edge with rx_valid high and
// rx_stall low. Parsed messages leave on the result ports with msg_valid;
// a result transaction completes at an edge with msg_valid high and
// msg_stall low. The mode_button register is written through cfg_valid,
// cfg_ready and cfg_data; cfg_ready is always high, so a write lands at
// any edge with cfg_valid high. Write it only while the block is idle.
//
// Throughput is one byte per cycle while rx_stall is low. A byte that
// completes a message passes, when the output is not stalled, into the
// command queue, then through the trig table lookup and products into
// the product stage, then through truncation into the output register,
// from which it leaves as a result. Bytes inside a message give no result.
// When msg_stall is held, the output register and the product stage hold
// and the four-entry queue fills; rx_stall rises only once the queue is
// full. A synchronous reset returns the parser to waiting for a lead byte,
// clears the mode bit, sets mode_button to 2 and empties the pipeline.
module controller_packet_parser_core #(
  parameter int TRIG_FRAC_BITS = cpp_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rx_valid,
  output logic              rx_stall,
  input  logic [7:0]        rx_byte,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data,
  output logic              msg_valid,
  input  logic              msg_stall,
  output logic [2:0]        message_kind,
  output logic signed [9:0] joy_x,
  output logic signed [9:0] joy_y,
  output logic [7:0]        button_id,
  output logic [7:0]        slider_id,
  output logic [7:0]        slider_value,
  output logic [7:0]        text_char,
  output logic              mode_bit
);
  import cpp_pkg::*;

  logic     byte_take;
  logic     push;
  cpp_cmd_t push_cmd;
  logic     full;
  logic     pop;
  logic     not_empty;
  cpp_cmd_t pop_cmd;

  // The queue full flag is registered state, so rx_stall never depends on
  // rx_valid or on the output side in the same cycle.
  assign rx_stall  = full;
  assign byte_take = rx_valid && !rx_stall;
  assign cfg_ready = 1'b1;

  cpp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_take (byte_take),
    .rx_byte   (rx_byte),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  cpp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_cmd   (pop_cmd)
  );

  cpp_back #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (not_empty),
    .cmd          (pop_cmd),
    .cmd_pop      (pop),
    .msg_valid    (msg_valid),
    .msg_stall    (msg_stall),
    .message_kind (message_kind),
    .joy_x        (joy_x),
    .joy_y        (joy_y),
    .button_id    (button_id),
    .slider_id    (slider_id),
    .slider_value (slider_value),
    .text_char    (text_char),
    .mode_bit     (mode_bit)
  );

endmodule

### verif/controller_packet_parser_core_tb.sv
// Self-checking testbench for controller_packet_parser_core: a directed table
// and random byte streams are checked against typed-in results or an in-bench model.
// Depends on cpp_pkg and the controller_packet_parser_core RTL.
module controller_packet_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cpp_pkg::*;

  localparam int FRAC = TRIG_FRAC_BITS_DEF;
  localparam int RANDOM_PHASES = 6;
  localparam int BYTES_PER_PHASE = 155;
  // Cycles to let pass after the last result before touching mode_button.
  // The pipeline is three deep, so this is generous.
  localparam int SETTLE_CYCLES = 8;

  // One parsed message as it appears on the result ports.
  typedef struct packed {
    logic [2:0]        kind;
    logic signed [9:0] x;
    logic signed [9:0] y;
    logic [7:0]        button;
    logic [7:0]        slider;
    logic [7:0]        level;
    logic [7:0]        ch;
    logic              mode;
  } msg_t;

  // One row of the directed table. Rows with a known result carry it typed
  // in; all other rows are checked against the parser model.
  typedef struct packed {
    logic [7:0] b;
    bit         known;
    msg_t       res;
  } row_t;

  // Parser states of the model.
  typedef enum logic [3:0] {
    ST_LEAD, ST_JOY_SPEED, ST_JOY_DIR, ST_JOY_END, ST_BTN_ID, ST_BTN_END,
    ST_SLD_ID, ST_SLD_VAL, ST_SLD_END, ST_TEXT
  } parse_state_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              rx_valid = 1'b0;
  logic              rx_stall;
  logic [7:0]        rx_byte = 8'd0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [7:0]        cfg_data = 8'd0;
  logic              msg_valid;
  logic              msg_stall = 1'b0;
  logic [2:0]        message_kind;
  logic signed [9:0] joy_x;
  logic signed [9:0] joy_y;
  logic [7:0]        button_id;
  logic [7:0]        slider_id;
  logic [7:0]        slider_value;
  logic [7:0]        text_char;
  logic              mode_bit;

  // Model state: parser position, held bytes, mode flag and the register.
  parse_state_t parse_state;
  logic [7:0]   held_a;
  logic [7:0]   held_b;
  logic         mode_flag;
  logic [7:0]   toggle_id;

  // Cosine and sine tables of the model, Q(FRAC), built from reals.
  int cos_tab[TRIG_ROM_SIZE];
  int sin_tab[TRIG_ROM_SIZE];

  msg_t pending_msgs[$];
  int   mismatch_count = 0;

  // Set by the sender together with each byte; when known_row is high the
  // typed-in result replaces the model's prediction for that transaction.
  bit   known_row = 1'b0;
  msg_t known_result = '0;

  // Calm stretches: while set, that side never idles.
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  controller_packet_parser_core DUT (
    .clk          (clk),
    .rst          (rst),
    .rx_valid     (rx_valid),
    .rx_stall     (rx_stall),
    .rx_byte      (rx_byte),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .msg_valid    (msg_valid),
    .msg_stall    (msg_stall),
    .message_kind (message_kind),
    .joy_x        (joy_x),
    .joy_y        (joy_y),
    .button_id    (button_id),
    .slider_id    (slider_id),
    .slider_value (slider_value),
    .text_char    (text_char),
    .mode_bit     (mode_bit)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Rounds half away from zero.
  function automatic int round_away(input real v);
    if (v >= 0.0) begin
      return $rtoi(v + 0.5);
    end
    return -$rtoi(-v + 0.5);
  endfunction

  // Each entry is folded onto the first quadrant, so that quadrant
  // boundaries come out exactly, then rounded and clamped to 2^F-1 on top.
  function automatic void build_trig_tables();
    int  j;
    int  m;
    bit  cneg;
    int  top;
    real one;
    real ang;
    one = 2.0 ** FRAC;
    top = (1 << FRAC) - 1;
    for (int k = 0; k < TRIG_ROM_SIZE; k++) begin
      j = (k <= TRIG_HALF_ROM) ? k : TRIG_ROM_SIZE - k;
      m = j;
      cneg = 1'b0;
      if (j > 49) begin
        m = TRIG_HALF_ROM - j;
        cneg = 1'b1;
      end
      ang = 3.14159265358979323846 * m / TRIG_HALF_ROM;
      cos_tab[k] = round_away(one * $cos(ang));
      sin_tab[k] = round_away(one * $sin(ang));
      if (cneg) cos_tab[k] = -cos_tab[k];
      if (k > TRIG_HALF_ROM) sin_tab[k] = -sin_tab[k];
      if (cos_tab[k] > top) cos_tab[k] = top;
      if (sin_tab[k] > top) sin_tab[k] = top;
    end
  endfunction

  // Magnitude times a table entry, scaled down and truncated toward zero.
  function automatic logic signed [9:0] scale_toward_zero(input longint mag,
                                                          input int entry);
    longint p;
    p = mag * entry;
    if (p < 0) begin
      return 10'(-((-p) >>> FRAC));
    end
    return 10'(p >>> FRAC);
  endfunction

  // Advances the parser model by one byte. Returns 1 and fills r when the
  // byte completes a message.
  function automatic bit parse_byte(input logic [7:0] b, output msg_t r);
    int     diff;
    int     d;
    int     idx;
    longint mag;
    bit     emit;
    r = '0;
    emit = 1'b0;
    case (parse_state)
      ST_JOY_SPEED: begin
        held_a = b;
        parse_state = ST_JOY_DIR;
      end
      ST_JOY_DIR: begin
        held_b = b;
        parse_state = ST_JOY_END;
      end
      ST_JOY_END: begin
        // The end byte's value does not matter. A speed of exactly 49 has
        // no sign, so the angle sits at the half turn whatever the direction.
        diff = int'(held_a) - int'(SPEED_ZERO);
        mag = 2 * ((diff < 0) ? -diff : diff);
        d = TRIG_HALF_ROM;
        if (diff > 0) d = TRIG_HALF_ROM + int'(held_b);
        else if (diff < 0) d = TRIG_HALF_ROM - int'(held_b);
        idx = (d + 2 * TRIG_ROM_SIZE) % TRIG_ROM_SIZE;
        r.kind = KIND_JOY;
        r.x = scale_toward_zero(mag, cos_tab[idx]);
        r.y = scale_toward_zero(mag, sin_tab[idx]);
        emit = 1'b1;
        parse_state = ST_LEAD;
      end
      ST_BTN_ID: begin
        held_a = b;
        parse_state = ST_BTN_END;
      end
      ST_BTN_END: begin
        // The toggle lands with the end byte, so this result already
        // shows the new mode.
        if (held_a == toggle_id) mode_flag = !mode_flag;
        r.kind = KIND_BTN;
        r.button = held_a;
        emit = 1'b1;
        parse_state = ST_LEAD;
      end
      ST_SLD_ID: begin
        held_a = b;
        parse_state = ST_SLD_VAL;
      end
      ST_SLD_VAL: begin
        held_b = b;
        parse_state = ST_SLD_END;
      end
      ST_SLD_END: begin
        r.kind = KIND_SLD;
        r.slider = held_a;
        r.level = held_b;
        emit = 1'b1;
        parse_state = ST_LEAD;
      end
      ST_TEXT: begin
        // Inside text every byte is a character, lead bytes included;
        // only the terminator leaves.
        if (b == TEXT_END) begin
          r.kind = KIND_TEXT_END;
          parse_state = ST_LEAD;
        end else begin
          r.kind = KIND_TEXT;
          r.ch = b;
        end
        emit = 1'b1;
      end
      default: begin
        if (b == LEAD_JOY) parse_state = ST_JOY_SPEED;
        else if (b == LEAD_BTN) parse_state = ST_BTN_ID;
        else if (b == LEAD_SLD) parse_state = ST_SLD_ID;
        else if (b == LEAD_TEXT) parse_state = ST_TEXT;
        else begin
          // Any other lead, the text terminator among them, is reported
          // as unrecognized with all data fields zero.
          parse_state = ST_LEAD;
          r.kind = KIND_UNKNOWN;
          emit = 1'b1;
        end
      end
    endcase
    r.mode = mode_flag;
    return emit;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Scoreboard and model update. Everything is sampled at the rising edge,
  // while inputs only move at the falling edge, so there is no race.
  always @(posedge clk) begin : watch
    msg_t pred;
    msg_t want;
    msg_t got;
    bit   emitted;
    if (rst) begin
      parse_state = ST_LEAD;
      held_a = 8'd0;
      held_b = 8'd0;
      mode_flag = 1'b0;
      toggle_id = 8'd2;
    end else begin
      if (cfg_valid && cfg_ready) begin
        toggle_id = cfg_data;
      end
      if (rx_valid && !rx_stall) begin
        emitted = parse_byte(rx_byte, pred);
        if (known_row) begin
          pending_msgs.push_back(known_result);
        end else if (emitted) begin
          pending_msgs.push_back(pred);
        end
      end
      if (msg_valid && !msg_stall) begin
        got = '{message_kind, joy_x, joy_y, button_id, slider_id, slider_value,
                text_char, mode_bit};
        if (pending_msgs.size() == 0) begin
          $error("unexpected result transaction: message_kind %0d", message_kind);
          mismatch_count++;
        end else begin
          want = pending_msgs.pop_front();
          check_field("message_kind", want.kind, got.kind);
          check_field("joy_x", int'(want.x), int'(got.x));
          check_field("joy_y", int'(want.y), int'(got.y));
          check_field("button_id", want.button, got.button);
          check_field("slider_id", want.slider, got.slider);
          check_field("slider_value", want.level, got.level);
          check_field("text_char", want.ch, got.ch);
          check_field("mode_bit", want.mode, got.mode);
        end
      end
    end
  end

  // Half the draws idle not at all; the rest draw a uniform idle length, zero included.
  function automatic int pick_wait();
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 15);
  endfunction

  // Receiving side: before each result transaction, stall a drawn number
  // of cycles, then take the result as soon as it shows up.
  initial begin : receiver
    int n;
    wait (!rst);
    @(negedge clk);
    forever begin
      n = rx_calm ? 0 : pick_wait();
      if (n > 0) begin
        msg_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      msg_stall = 1'b0;
      @(posedge clk);
      while (!msg_valid) @(posedge clk);
      @(negedge clk);
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
    end
  end

  // Sends one byte transaction. Entered and left at a falling edge. Valid
  // stays high between back-to-back bytes and drops only for a gap.
  task automatic send_byte(input logic [7:0] b, input bit known, input msg_t res);
    int gap;
    gap = tx_calm ? 0 : pick_wait();
    if (gap > 0) begin
      rx_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_byte = b;
    known_row = known;
    known_result = res;
    rx_valid = 1'b1;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    @(negedge clk);
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
  endtask

  // Holds the sender until every expected result has arrived, then lets
  // the pipeline settle, since bytes inside a message leave no trace.
  task automatic wait_for_drain();
    rx_valid = 1'b0;
    while (pending_msgs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode_button(input logic [7:0] v);
    cfg_data = v;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // One random message: mostly well-formed with random content, some
  // stray bytes. A stray lead byte also breaks up whatever follows it.
  task automatic send_random_message(output int n);
    int         pick;
    int         len;
    logic [7:0] v;
    n = 0;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      send_byte(LEAD_JOY, 1'b0, '0);
      v = ($urandom_range(0, 7) == 0) ? SPEED_ZERO : 8'($urandom_range(0, 255));
      send_byte(v, 1'b0, '0);
      send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      n = 4;
    end else if (pick < 50) begin
      send_byte(LEAD_BTN, 1'b0, '0);
      v = ($urandom_range(0, 1) == 0) ? toggle_id : 8'($urandom_range(0, 255));
      send_byte(v, 1'b0, '0);
      send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      n = 3;
    end else if (pick < 65) begin
      send_byte(LEAD_SLD, 1'b0, '0);
      send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      n = 4;
    end else if (pick < 85) begin
      send_byte(LEAD_TEXT, 1'b0, '0);
      len = $urandom_range(0, 6);
      for (int i = 0; i < len; i++) begin
        v = 8'($urandom_range(0, 255));
        if (v == TEXT_END) v = LEAD_JOY;
        send_byte(v, 1'b0, '0);
      end
      send_byte(TEXT_END, 1'b0, '0);
      n = len + 2;
    end else begin
      send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      n = 1;
    end
  endtask

  function automatic row_t bare_row(input logic [7:0] b);
    return '{b, 1'b0, msg_t'('0)};
  endfunction

  function automatic row_t typed_row(input logic [7:0] b, input logic [2:0] kind,
                                     input int x, input int y, input int btn,
                                     input int sld, input int lvl, input int ch,
                                     input bit mode);
    msg_t r;
    r = '{kind, 10'(x), 10'(y), 8'(btn), 8'(sld), 8'(lvl), 8'(ch), mode};
    return '{b, 1'b1, r};
  endfunction

  initial begin : stimulus
    row_t       dir_rows[$];
    logic [7:0] cfg_vals[RANDOM_PHASES];
    int         sent;
    int         n;
    build_trig_tables();

    // Directed table, run with mode_button at its reset value of 2.
    // Unrecognized leads: the lowest byte and the text terminator.
    dir_rows.push_back(typed_row(8'd0, KIND_UNKNOWN, 0, 0, 0, 0, 0, 0, 1'b0));
    dir_rows.push_back(typed_row(TEXT_END, KIND_UNKNOWN, 0, 0, 0, 0, 0, 0, 1'b0));
    // Joystick at speed 49 has no magnitude, whatever the direction.
    dir_rows.push_back(bare_row(LEAD_JOY));
    dir_rows.push_back(bare_row(SPEED_ZERO));
    dir_rows.push_back(bare_row(8'd255));
    dir_rows.push_back(typed_row(8'd0, KIND_JOY, 0, 0, 0, 0, 0, 0, 1'b0));
    // Top speed, direction 0: full magnitude at the half turn.
    dir_rows.push_back(bare_row(LEAD_JOY));
    dir_rows.push_back(bare_row(8'd255));
    dir_rows.push_back(bare_row(8'd0));
    dir_rows.push_back(typed_row(8'd255, KIND_JOY, -412, 0, 0, 0, 0, 0, 1'b0));
    // Top speed, direction 99 wraps to angle 0, where cosine is clamped.
    dir_rows.push_back(bare_row(LEAD_JOY));
    dir_rows.push_back(bare_row(8'd255));
    dir_rows.push_back(bare_row(8'd99));
    dir_rows.push_back(typed_row(8'd7, KIND_JOY, 411, 0, 0, 0, 0, 0, 1'b0));
    // Lowest speed, largest direction: the angle wraps the other way.
    dir_rows.push_back(bare_row(LEAD_JOY));
    dir_rows.push_back(bare_row(8'd0));
    dir_rows.push_back(bare_row(8'd255));
    dir_rows.push_back(bare_row(8'd128));
    // Press of the mode button toggles the mode bit on its end byte.
    dir_rows.push_back(bare_row(LEAD_BTN));
    dir_rows.push_back(bare_row(8'd2));
    dir_rows.push_back(typed_row(8'd0, KIND_BTN, 0, 0, 2, 0, 0, 0, 1'b1));
    // Text with a lead byte as a character, then an empty text.
    dir_rows.push_back(bare_row(LEAD_TEXT));
    dir_rows.push_back(typed_row(LEAD_JOY, KIND_TEXT, 0, 0, 0, 0, 0, 251, 1'b1));
    dir_rows.push_back(typed_row(TEXT_END, KIND_TEXT_END, 0, 0, 0, 0, 0, 0, 1'b1));
    dir_rows.push_back(bare_row(LEAD_TEXT));
    dir_rows.push_back(typed_row(TEXT_END, KIND_TEXT_END, 0, 0, 0, 0, 0, 0, 1'b1));
    // Slider with extreme id and value.
    dir_rows.push_back(bare_row(LEAD_SLD));
    dir_rows.push_back(bare_row(8'd255));
    dir_rows.push_back(bare_row(8'd0));
    dir_rows.push_back(typed_row(8'd1, KIND_SLD, 0, 0, 0, 255, 0, 0, 1'b1));

    // Register settings of the random phases, both extremes among them.
    cfg_vals[0] = 8'd0;
    cfg_vals[1] = 8'd255;
    cfg_vals[2] = 8'd2;
    cfg_vals[3] = 8'($urandom_range(1, 254));
    cfg_vals[4] = 8'($urandom_range(0, 255));
    cfg_vals[5] = 8'd128;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].b, dir_rows[i].known, dir_rows[i].res);
    end
    known_row = 1'b0;

    // Each phase starts from an idle block: the sender holds off until all
    // expected results are in before the register is rewritten.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_for_drain();
      write_mode_button(cfg_vals[p]);
      sent = 0;
      while (sent < BYTES_PER_PHASE) begin
        send_random_message(n);
        sent += n;
      end
    end

    wait_for_drain();
    if (mismatch_count == 0 && pending_msgs.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### controller_packet_parser_core.f
hdl/cpp_pkg.sv
hdl/cpp_front.sv
hdl/cpp_queue.sv
hdl/cpp_back.sv
hdl/controller_packet_parser_core.sv
verif/controller_packet_parser_core_tb.sv
